/* rtl/mf3_pkg.sv */
// shared types, constants and helper functions for the 3x3 clipped-border median filter
// no dependencies; imported by every module of the block
`default_nettype none

package mf3_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;

    typedef logic [PIX_W-1:0] pix_t;
    // slot r*3+c of the 3x3 window, row 0 on top, column 2 newest
    typedef pix_t [8:0] win_t;
    typedef logic [CFG_W-1:0] cfg_data_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    localparam int unsigned DIM_MIN      = 3;
    localparam int unsigned WIDTH_RESET  = 640;
    localparam int unsigned HEIGHT_RESET = 480;

    localparam pix_t PIX_MIN = '0;
    localparam pix_t PIX_MAX = '1;

    // window slots dropped at each image edge
    localparam logic [8:0] CLIP_TOP    = 9'b000_000_111;
    localparam logic [8:0] CLIP_BOTTOM = 9'b111_000_000;
    localparam logic [8:0] CLIP_LEFT   = 9'b001_001_001;
    localparam logic [8:0] CLIP_RIGHT  = 9'b100_100_100;
    // dropped edge-centre slots pad low, dropped corner slots pad high, so the
    // wanted middle pair always lands on sorted ranks 3 and 4 of nine
    localparam logic [8:0] LOW_PAD     = 9'b010_101_010;

    // one operation handed from the front to the back
    typedef struct packed {
        pix_t pixel;      // bottom row value, zero while draining
        logic col_shift;  // shift a fresh column in, else shift zeros
        logic wr_en;      // update the line memory
        logic gate_a;     // upper line holds data of this frame
        logic gate_b;     // middle line holds data of this frame
        logic pre;        // right-edge result taken from a zero shift first
        logic prod;       // a result leaves for this item
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic frame_end;
    } op_t;

    typedef struct packed {
        logic full;       // all nine values inside the image
        logic frame_end;
    } sort_tag_t;

    function automatic win_t win_shift(win_t v, pix_t top, pix_t mid, pix_t bot);
        win_t r;
        r[0] = v[1];
        r[1] = v[2];
        r[2] = top;
        r[3] = v[4];
        r[4] = v[5];
        r[5] = mid;
        r[6] = v[7];
        r[7] = v[8];
        r[8] = bot;
        return r;
    endfunction

    function automatic win_t pad_window(win_t v, logic [8:0] clip);
        win_t r;
        for (int i = 0; i < 9; i++) begin
            if (clip[i]) begin
                r[i] = LOW_PAD[i] ? PIX_MIN : PIX_MAX;
            end else begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

    // one phase of odd-even transposition sort, ascending
    function automatic win_t oet_phase(win_t v, logic odd);
        win_t r;
        r = v;
        if (!odd) begin
            for (int k = 0; k < 4; k++) begin
                if (v[2*k] > v[2*k+1]) begin
                    r[2*k]   = v[2*k+1];
                    r[2*k+1] = v[2*k];
                end
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (v[2*k+1] > v[2*k+2]) begin
                    r[2*k+1] = v[2*k+2];
                    r[2*k+2] = v[2*k+1];
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/median_filter_3x3_clipped_border.sv */
// 3x3 median filter with the window clipped at the image border
// 8-bit grey pixels arrive on s_* in raster order, one item per clock when s_ready is high,
// and filtered pixels leave on m_* in raster order; both sides use valid/ready.
// Interior pixels take the middle of nine values, edge pixels the floor mean of the middle
// two of six, corners the floor mean of the middle two of four.
// A result for pixel (r, c) is caused by the item one row and one pixel later, so the last
// image_width + 1 results of a frame are drained by that many flush items after the frame;
// a flush item sent mid-frame is taken and ignored. m_frame_end marks the last pixel.
// Throughput is one item per clock unless the output stalls, set by one line memory read
// and one line memory write of a column per item and the window update. An item taken from
// the queue passes the window stage, padding register, three sort stages and output register.
// Configuration (cfg_index 0: width, 1: height, clamped to 3..MAX) must be written by the
// user only while idle, which the block does not enforce, and restarts the frame position.
// Reset sets 640x480 and empties the pipeline; the line memory needs no clearing, as rows
// not yet written in the frame are gated to zero. A result waiting on m_ready low holds the
// back end; a four-entry queue keeps taking items until it fills, then s_ready drops.
`default_nettype none

module median_filter_3x3_clipped_border #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  mf3_pkg::cfg_index_t cfg_index,
    input  mf3_pkg::cfg_data_t  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  mf3_pkg::pix_t       s_pixel_in,
    input  logic                s_flush,
    output logic                m_valid,
    input  logic                m_ready,
    output mf3_pkg::pix_t       m_pixel_out,
    output logic                m_frame_end
);
    import mf3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          q_ready;
    logic          q_push;
    op_t           front_op;
    logic [AW-1:0] front_addr;
    logic          q_valid;
    logic          q_pop;
    op_t           back_op;
    logic [AW-1:0] back_addr;

    mf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_in (s_pixel_in),
        .s_flush    (s_flush),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_op       (front_op),
        .q_addr     (front_addr)
    );

    mf3_queue #(
        .AW    (AW),
        .DEPTH (4)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .op_in     (front_op),
        .addr_in   (front_addr),
        .not_full  (q_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .op_out    (back_op),
        .addr_out  (back_addr)
    );

    mf3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_op        (back_op),
        .q_addr      (back_addr),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire

/* rtl/mf3_front.sv */
// front end: configuration registers, raster position counters and item classification
// depends on mf3_pkg; feeds operations into mf3_queue
`default_nettype none

module mf3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  mf3_pkg::cfg_index_t            cfg_index,
    input  mf3_pkg::cfg_data_t             cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mf3_pkg::pix_t                  s_pixel_in,
    input  logic                           s_flush,
    input  logic                           q_ready,
    output logic                           q_push,
    output mf3_pkg::op_t                   q_op,
    output logic [$clog2(MAX_WIDTH)-1:0]   q_addr
);
    import mf3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        int unsigned r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [CW-1:0] w_reg, w_next, ic_reg, ic_next;
    logic [RW-1:0] h_reg, h_next, ir_reg, ir_next;
    logic          draining;
    logic          drop;
    logic          accept;
    logic          pre;
    logic          main_out;

    assign s_ready = q_ready;
    assign q_addr  = ic_reg[AW-1:0];

    always_comb begin
        draining = (ir_reg == h_reg);
        // a flush while pixels are still coming has no effect
        drop     = s_flush && !draining;
        accept   = s_valid && q_ready;
        q_push   = accept && !drop;

        pre      = (ic_reg == '0) && (ir_reg >= RW'(2));
        main_out = (ic_reg != '0) && (ir_reg != '0);

        q_op.pixel     = draining ? PIX_MIN : s_pixel_in;
        q_op.col_shift = (ic_reg < w_reg);
        q_op.wr_en     = !draining;
        q_op.gate_a    = (ir_reg >= RW'(2));
        q_op.gate_b    = (ir_reg != '0);
        q_op.pre       = pre;
        q_op.prod      = pre || main_out;
        q_op.top       = pre ? (ir_reg == RW'(2)) : (ir_reg == RW'(1));
        q_op.bottom    = !pre && draining;
        q_op.left      = !pre && (ic_reg == CW'(1));
        q_op.right     = pre || (ic_reg == w_reg);
        q_op.frame_end = main_out && draining && (ic_reg == w_reg);

        w_next  = w_reg;
        h_next  = h_reg;
        ic_next = ic_reg;
        ir_next = ir_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    w_next = CW'(clamp_dim(32'(cfg_data), 32'(MAX_WIDTH)));
                end
                REG_IMAGE_HEIGHT: begin
                    h_next = RW'(clamp_dim(32'(cfg_data), 32'(MAX_HEIGHT)));
                end
            endcase
            ic_next = '0;
            ir_next = '0;
        end else if (q_push) begin
            if (!draining) begin
                if (ic_reg == w_reg - CW'(1)) begin
                    ic_next = '0;
                    ir_next = ir_reg + RW'(1);
                end else begin
                    ic_next = ic_reg + CW'(1);
                end
            end else if (ic_reg == w_reg) begin
                // drain done, next frame starts
                ic_next = '0;
                ir_next = '0;
            end else begin
                ic_next = ic_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg  <= CW'(clamp_dim(WIDTH_RESET, 32'(MAX_WIDTH)));
            h_reg  <= RW'(clamp_dim(HEIGHT_RESET, 32'(MAX_HEIGHT)));
            ic_reg <= '0;
            ir_reg <= '0;
        end else begin
            w_reg  <= w_next;
            h_reg  <= h_next;
            ic_reg <= ic_next;
            ir_reg <= ir_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mf3_queue.sv */
// short operation queue between the front end and the back end
// depends on mf3_pkg for the operation type
`default_nettype none

module mf3_queue #(
    parameter int AW    = 10,
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mf3_pkg::op_t  op_in,
    input  logic [AW-1:0] addr_in,
    output logic          not_full,
    input  logic          pop,
    output logic          out_valid,
    output mf3_pkg::op_t  op_out,
    output logic [AW-1:0] addr_out
);
    import mf3_pkg::*;

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    op_t             op_mem   [DEPTH];
    logic [AW-1:0]   addr_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]  count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign not_full  = (count_reg != CNW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign op_out    = op_mem[rd_ptr_reg];
    assign addr_out  = addr_mem[rd_ptr_reg];

    always_comb begin
        do_push     = push && not_full;
        do_pop      = pop && out_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            op_mem[wr_ptr_reg]   <= op_in;
            addr_mem[wr_ptr_reg] <= addr_in;
        end
    end

endmodule

`default_nettype wire

/* rtl/mf3_sort.sv */
// pipelined odd-even transposition sort of nine values, three phases per register stage
// depends on mf3_pkg for the window type and the phase function
`default_nettype none

module mf3_sort (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  mf3_pkg::win_t       in_win,
    input  mf3_pkg::sort_tag_t  in_tag,
    output logic                out_valid,
    output mf3_pkg::pix_t       out_lo,
    output mf3_pkg::pix_t       out_hi,
    output mf3_pkg::sort_tag_t  out_tag
);
    import mf3_pkg::*;

    localparam int STAGES = 3;

    win_t              stage_in  [STAGES];
    win_t              stage_out [STAGES];
    win_t              win_reg   [STAGES];
    sort_tag_t         tag_reg   [STAGES];
    logic [STAGES-1:0] valid_reg;

    always_comb begin
        stage_in[0] = in_win;
        for (int s = 1; s < STAGES; s++) begin
            stage_in[s] = win_reg[s-1];
        end
        // phase parity alternates across the whole chain of nine phases
        for (int s = 0; s < STAGES; s++) begin
            stage_out[s] = oet_phase(oet_phase(oet_phase(stage_in[s], 1'(s % 2)),
                                               !1'(s % 2)), 1'(s % 2));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int s = 0; s < STAGES; s++) begin
                win_reg[s] <= stage_out[s];
            end
            for (int s = 1; s < STAGES; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_lo    = win_reg[STAGES-1][3];
    assign out_hi    = win_reg[STAGES-1][4];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

`default_nettype wire

/* rtl/mf3_back.sv */
// back end: line memory, 3x3 window, edge padding, sorter and output register
// depends on mf3_pkg and mf3_sort; takes operations from mf3_queue
`default_nettype none

module mf3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  mf3_pkg::op_t                 q_op,
    input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mf3_pkg::pix_t                m_pixel_out,
    output logic                         m_frame_end
);
    import mf3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // upper byte: line two rows up, lower byte: line one row up
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic          adv;
    logic          op1_valid_reg;
    op_t           op1_reg;
    logic [AW-1:0] op1_addr_reg;

    win_t          win_reg, win_next;
    win_t          win_zero_shift;
    win_t          win_base;
    win_t          med_win;
    pix_t          col_a, col_b, col_c;
    logic [8:0]    clip;

    logic          snap_valid_reg;
    win_t          snap_win_reg;
    sort_tag_t     snap_tag_reg;

    logic          sort_valid;
    pix_t          sort_lo, sort_hi;
    sort_tag_t     sort_tag;
    logic [PIX_W:0] pair_sum;

    logic          m_valid_reg;
    pix_t          m_pixel_out_reg;
    logic          m_frame_end_reg;

    // the whole back end moves together whenever the output register can take a result
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    always_comb begin
        col_a = op1_reg.gate_a ? rd_data_reg[2*PIX_W-1:PIX_W] : PIX_MIN;
        col_b = op1_reg.gate_b ? rd_data_reg[PIX_W-1:0] : PIX_MIN;
        col_c = op1_reg.pixel;
        if (!op1_reg.col_shift) begin
            col_a = PIX_MIN;
            col_b = PIX_MIN;
            col_c = PIX_MIN;
        end

        win_zero_shift = win_shift(win_reg, PIX_MIN, PIX_MIN, PIX_MIN);
        win_base       = op1_reg.pre ? win_zero_shift : win_reg;
        win_next       = win_shift(win_base, col_a, col_b, col_c);
        med_win        = op1_reg.pre ? win_zero_shift : win_next;

        clip = (op1_reg.top    ? CLIP_TOP    : '0)
             | (op1_reg.bottom ? CLIP_BOTTOM : '0)
             | (op1_reg.left   ? CLIP_LEFT   : '0)
             | (op1_reg.right  ? CLIP_RIGHT  : '0);
    end

    // line memory: read for the item entering, write for the item leaving the window stage
    always_ff @(posedge aclk) begin
        if (q_pop && q_op.col_shift) begin
            rd_data_reg <= line_mem[q_addr];
        end
        if (adv && op1_valid_reg && op1_reg.wr_en) begin
            line_mem[op1_addr_reg] <= {col_b, op1_reg.pixel};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op1_valid_reg  <= 1'b0;
            snap_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            win_reg        <= '0;
        end else if (adv) begin
            op1_valid_reg  <= q_valid;
            snap_valid_reg <= op1_valid_reg && op1_reg.prod;
            m_valid_reg    <= sort_valid;
            if (op1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    assign pair_sum = {1'b0, sort_lo} + {1'b0, sort_hi};

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg                <= q_op;
            op1_addr_reg           <= q_addr;
            snap_win_reg           <= pad_window(med_win, clip);
            snap_tag_reg.full      <= (clip == '0);
            snap_tag_reg.frame_end <= op1_reg.frame_end;
            m_pixel_out_reg        <= sort_tag.full ? sort_hi : pair_sum[PIX_W:1];
            m_frame_end_reg        <= sort_tag.frame_end;
        end
    end

    mf3_sort u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (snap_valid_reg),
        .in_win    (snap_win_reg),
        .in_tag    (snap_tag_reg),
        .out_valid (sort_valid),
        .out_lo    (sort_lo),
        .out_hi    (sort_hi),
        .out_tag   (sort_tag)
    );

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_out_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

`default_nettype wire
